FILE: rtl/eased_rect_animation_stepper_top_defines.svh
// Assertion macros for the checker file of the rectangle animation stepper.
`ifndef EASED_RECT_ANIMATION_STEPPER_TOP_DEFINES_SVH
`define EASED_RECT_ANIMATION_STEPPER_TOP_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent. The check is off while reset is low.
`define ERAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("eras check failed");

// The same check, also active while reset is low.
`define ERAS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("eras reset check failed");

`endif

FILE: rtl/eras_pkg.sv
package eras_pkg;

    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_phase;
    typedef logic [1:0] t_mode;

    localparam t_kind KIND_START = 2'd0;
    localparam t_kind KIND_TICK  = 2'd1;
    localparam t_kind KIND_LOAD  = 2'd2;

    localparam t_phase PH_STOPPED = 2'd0;
    localparam t_phase PH_IDLE    = 2'd1;
    localparam t_phase PH_RUNNING = 2'd2;

    localparam t_mode MODE_SMOOTH = 2'd0;
    localparam t_mode MODE_INOUT  = 2'd1;
    localparam t_mode MODE_OUTQ   = 2'd2;
    localparam t_mode MODE_INQ    = 2'd3;

    // Progress step of 0.042 in unsigned Q1.16.
    localparam logic [16:0] STEP_Q16 = 17'd2753;

endpackage

FILE: rtl/eased_rect_animation_stepper_top.sv
// Channel | Direction | Handshake                  | Word
// input   | in        | i_in_valid / o_in_ready    | i_kind, i_target_x/y/w/h/r
// output  | out       | o_out_valid / i_out_ready  | o_cur_x/y/w/h/r, o_anim_state
// config  | in        | i_cfg_we (no wait)         | i_cfg_wdata (ease mode)
//
// A start, a load, an unused kind or a tick that leaves the animation stopped goes from S_IDLE straight to S_DONE.
// A running tick uses one 33 x 19 bit multiplier: it squares the progress, multiplies once more
// for the cubic with the smoothstep curve only, then scales each of the five deltas.
// The input is not ready while a word is in work. A finished word waits in the output register,
// and the next word cannot complete until that register has been taken.
// Synchronous active-low reset clears the phase, the progress, the rectangle and the ease mode.
module eased_rect_animation_stepper_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  eras_pkg::t_mode       i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  eras_pkg::t_kind       i_kind,
    input  logic signed [15:0]    i_target_x,
    input  logic signed [15:0]    i_target_y,
    input  logic        [7:0]     i_target_w,
    input  logic        [7:0]     i_target_h,
    input  logic        [7:0]     i_target_r,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [15:0]    o_cur_x,
    output logic signed [15:0]    o_cur_y,
    output logic        [7:0]     o_cur_w,
    output logic        [7:0]     o_cur_h,
    output logic        [7:0]     o_cur_r,
    output eras_pkg::t_phase      o_anim_state
);
    import eras_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_CUBE = 3'd2;
    localparam logic [2:0] S_EASE = 3'd3;
    localparam logic [2:0] S_MOVE = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // Field order in the move sweep.
    localparam logic [2:0] FLD_X    = 3'd0;
    localparam logic [2:0] FLD_Y    = 3'd1;
    localparam logic [2:0] FLD_W    = 3'd2;
    localparam logic [2:0] FLD_H    = 3'd3;
    localparam logic [2:0] FLD_R    = 3'd4;
    localparam logic [2:0] FLD_LAST = 3'd5;

    logic [2:0]          r_state, n_state;
    t_mode               r_mode;
    t_phase              r_phase, n_phase;
    logic [16:0]         r_prog, n_prog;
    logic signed [15:0]  r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic [7:0]          r_size_w, n_size_w, r_size_h, n_size_h, r_radius, n_radius;
    logic signed [15:0]  r_tgt_x, n_tgt_x, r_tgt_y, n_tgt_y;
    logic [7:0]          r_tgt_w, n_tgt_w, r_tgt_h, n_tgt_h, r_tgt_r, n_tgt_r;
    logic signed [51:0]  r_prod, n_prod;
    logic [15:0]         r_ease, n_ease;
    logic [2:0]          r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    logic signed [15:0]  r_out_x, n_out_x, r_out_y, n_out_y;
    logic [7:0]          r_out_w, n_out_w, r_out_h, n_out_h, r_out_r, n_out_r;
    t_phase              r_out_state, n_out_state;

    // Tick bookkeeping on the word at the input.
    logic [16:0]         tick_prog;
    t_phase              tick_phase;

    // Shared multiplier.
    logic signed [32:0]  mul_a;
    logic signed [18:0]  mul_b;
    logic signed [51:0]  mul_p;
    logic [15:0]         sq_in;
    logic [17:0]         cube_m;

    // Ease and move datapath.
    logic [31:0]         pp;
    logic [32:0]         inout_t;
    logic [32:0]         outq_t;
    logic [15:0]         ease_val;
    logic signed [15:0]  dx, dy;
    logic [7:0]          dw, dh, dr;
    logic signed [15:0]  mul_delta;
    logic [2:0]          fin_idx;
    logic signed [16:0]  fin_cur;
    logic signed [33:0]  fin_sum;
    logic signed [33:0]  fin_adj;
    logic [15:0]         fin_val;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cur_x      = r_out_x;
    assign o_cur_y      = r_out_y;
    assign o_cur_w      = r_out_w;
    assign o_cur_h      = r_out_h;
    assign o_cur_r      = r_out_r;
    assign o_anim_state = r_out_state;

    // An idle animation restarts from zero; a running one advances by one step.
    // Progress of 1.0 or more stops the animation.
    always_comb begin
        priority if (r_phase == PH_IDLE) begin
            tick_prog = '0;
        end else if (r_phase == PH_RUNNING) begin
            tick_prog = r_prog + STEP_Q16;
        end else begin
            tick_prog = r_prog;
        end
        if (tick_prog[16]) begin
            tick_phase = PH_STOPPED;
        end else if (r_phase == PH_IDLE) begin
            tick_phase = PH_RUNNING;
        end else begin
            tick_phase = r_phase;
        end
    end

    // The in-out quad curve squares the distance to 1.0 in its second half.
    // Progress stays below 1.0 while running, so the folded value fits in 16 bits.
    assign sq_in  = (r_mode == MODE_INOUT && r_prog[15]) ? 16'(17'h10000 - r_prog)
                                                           : r_prog[15:0];
    assign cube_m = 18'h30000 - {1'b0, r_prog[15:0], 1'b0};

    // Wrapped deltas toward the target.
    assign dx = r_tgt_x - r_pos_x;
    assign dy = r_tgt_y - r_pos_y;
    assign dw = r_tgt_w - r_size_w;
    assign dh = r_tgt_h - r_size_h;
    assign dr = r_tgt_r - r_radius;

    always_comb begin
        unique case (r_idx)
            FLD_X:   mul_delta = dx;
            FLD_Y:   mul_delta = dy;
            FLD_W:   mul_delta = {{8{dw[7]}}, dw};
            FLD_H:   mul_delta = {{8{dh[7]}}, dh};
            FLD_R:   mul_delta = {{8{dr[7]}}, dr};
            default: mul_delta = '0;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_SQ: begin
                mul_a = {17'd0, sq_in};
                mul_b = {3'd0, sq_in};
            end
            S_CUBE: begin
                mul_a = {1'b0, r_prod[31:0]};
                mul_b = {1'b0, cube_m};
            end
            default: begin
                mul_a = {{17{mul_delta[15]}}, mul_delta};
                mul_b = {3'd0, r_ease};
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Ease value in Q0.16 from the registered products.
    assign pp      = r_prod[31:0];
    assign inout_t = 33'h1_0000_0000 - {pp, 1'b0};
    assign outq_t  = {r_prog[15:0], 17'd0} - {1'b0, pp};

    always_comb begin
        unique case (r_mode)
            MODE_SMOOTH: ease_val = r_prod[47:32];
            MODE_INOUT:  ease_val = r_prog[15] ? inout_t[31:16] : pp[30:15];
            MODE_OUTQ:   ease_val = outq_t[31:16];
            MODE_INQ:    ease_val = pp[31:16];
            default:     ease_val = pp[31:16];
        endcase
    end

    // The field whose product sits in r_prod is finished while the next one multiplies.
    assign fin_idx = r_idx - 3'd1;

    always_comb begin
        unique case (fin_idx)
            FLD_X:   fin_cur = {r_pos_x[15], r_pos_x};
            FLD_Y:   fin_cur = {r_pos_y[15], r_pos_y};
            FLD_W:   fin_cur = {9'd0, r_size_w};
            FLD_H:   fin_cur = {9'd0, r_size_h};
            FLD_R:   fin_cur = {9'd0, r_radius};
            default: fin_cur = '0;
        endcase
    end

    // cur + delta * ease / 65536, truncated toward zero, then wrapped to the field width.
    assign fin_sum = {fin_cur[16], fin_cur, 16'd0} + {r_prod[32], r_prod[32:0]};
    assign fin_adj = fin_sum + (fin_sum[33] ? 34'sh0FFFF : 34'sh0);
    assign fin_val = fin_adj[31:16];

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_prog      = r_prog;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_size_w    = r_size_w;
        n_size_h    = r_size_h;
        n_radius    = r_radius;
        n_tgt_x     = r_tgt_x;
        n_tgt_y     = r_tgt_y;
        n_tgt_w     = r_tgt_w;
        n_tgt_h     = r_tgt_h;
        n_tgt_r     = r_tgt_r;
        n_prod      = r_prod;
        n_ease      = r_ease;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_w     = r_out_w;
        n_out_h     = r_out_h;
        n_out_r     = r_out_r;
        n_out_state = r_out_state;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DONE;
                    unique case (i_kind)
                        KIND_START: begin
                            if (r_phase == PH_STOPPED) begin
                                n_phase = PH_IDLE;
                            end
                        end
                        KIND_LOAD: begin
                            n_pos_x  = i_target_x;
                            n_pos_y  = i_target_y;
                            n_size_w = i_target_w;
                            n_size_h = i_target_h;
                            n_radius = i_target_r;
                        end
                        KIND_TICK: begin
                            n_prog  = tick_prog;
                            n_phase = tick_phase;
                            if (tick_phase == PH_RUNNING) begin
                                n_tgt_x = i_target_x;
                                n_tgt_y = i_target_y;
                                n_tgt_w = i_target_w;
                                n_tgt_h = i_target_h;
                                n_tgt_r = i_target_r;
                                n_state = S_SQ;
                            end else begin
                                n_pos_x  = i_target_x;
                                n_pos_y  = i_target_y;
                                n_size_w = i_target_w;
                                n_size_h = i_target_h;
                                n_radius = i_target_r;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SQ: begin
                n_prod  = mul_p;
                n_state = (r_mode == MODE_SMOOTH) ? S_CUBE : S_EASE;
            end
            S_CUBE: begin
                n_prod  = mul_p;
                n_state = S_EASE;
            end
            S_EASE: begin
                n_ease  = ease_val;
                n_idx   = FLD_X;
                n_state = S_MOVE;
            end
            S_MOVE: begin
                if (r_idx != FLD_LAST) begin
                    n_prod = mul_p;
                end
                if (r_idx != FLD_X) begin
                    unique case (fin_idx)
                        FLD_X:   n_pos_x  = fin_val;
                        FLD_Y:   n_pos_y  = fin_val;
                        FLD_W:   n_size_w = fin_val[7:0];
                        FLD_H:   n_size_h = fin_val[7:0];
                        FLD_R:   n_radius = fin_val[7:0];
                        default: n_radius = r_radius;
                    endcase
                end
                n_idx = r_idx + 3'd1;
                if (r_idx == FLD_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_pos_x;
                    n_out_y     = r_pos_y;
                    n_out_w     = r_size_w;
                    n_out_h     = r_size_h;
                    n_out_r     = r_radius;
                    n_out_state = r_phase;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_SMOOTH;
            r_phase     <= PH_STOPPED;
            r_prog      <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_size_w    <= '0;
            r_size_h    <= '0;
            r_radius    <= '0;
            r_idx       <= FLD_X;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_phase     <= n_phase;
            r_prog      <= n_prog;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_size_w    <= n_size_w;
            r_size_h    <= n_size_h;
            r_radius    <= n_radius;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt_x     <= n_tgt_x;
        r_tgt_y     <= n_tgt_y;
        r_tgt_w     <= n_tgt_w;
        r_tgt_h     <= n_tgt_h;
        r_tgt_r     <= n_tgt_r;
        r_prod      <= n_prod;
        r_ease      <= n_ease;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_w     <= n_out_w;
        r_out_h     <= n_out_h;
        r_out_r     <= n_out_r;
        r_out_state <= n_out_state;
    end

endmodule

FILE: rtl/eras_checker.sv
`include "eased_rect_animation_stepper_top_defines.svh"

module eras_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  eras_pkg::t_mode       i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  o_in_ready,
    input  eras_pkg::t_kind       i_kind,
    input  logic signed [15:0]    i_target_x,
    input  logic signed [15:0]    i_target_y,
    input  logic        [7:0]     i_target_w,
    input  logic        [7:0]     i_target_h,
    input  logic        [7:0]     i_target_r,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  logic signed [15:0]    o_cur_x,
    input  logic signed [15:0]    o_cur_y,
    input  logic        [7:0]     o_cur_w,
    input  logic        [7:0]     o_cur_h,
    input  logic        [7:0]     o_cur_r,
    input  eras_pkg::t_phase      o_anim_state
);
    import eras_pkg::*;

    // A stalled result word stays offered.
    `ERAS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // A stalled result word keeps its payload.
    `ERAS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_cur_x) && $stable(o_cur_y) && $stable(o_cur_w) && $stable(o_cur_h) && $stable(o_cur_r) && $stable(o_anim_state))

    // The block works on one word at a time.
    `ERAS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // Reset leaves no result word pending.
    `ERAS_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind eased_rect_animation_stepper_top eras_checker u_eras_checker (.*);
